FILE: rtl/fmv_pkg.sv
// Shared types, constants and helpers of the FIX message validator.
`timescale 1ns / 1ps
`default_nettype none

package fmv_pkg;

    // Intended message size limit; positions are carried modulo its span
    localparam int MAX_MESSAGE_BYTES = 65536;
    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES);

    localparam int TAG_W  = 32;
    localparam int SUM_W  = 8;
    localparam int BYTE_W = 8;

    // Output tdata: tag, offset, length, ok, error code, padded to bytes
    localparam int TDATA_RAW_W = TAG_W + 2 * POS_W + 1 + 3;
    localparam int TDATA_W     = ((TDATA_RAW_W + 7) / 8) * 8;

    // Result queue depth; two entries must be free to take one byte
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Message bytes of interest
    localparam logic [BYTE_W-1:0] SOH_BYTE   = 8'h01;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_EQUAL = 8'h3D;

    localparam logic [TAG_W-1:0] TAG_MSG_LEN  = 32'd9;
    localparam logic [TAG_W-1:0] TAG_CHECKSUM = 32'd10;

    // Result kinds carried on tuser
    localparam logic KIND_FIELD   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        ERR_NONE          = 3'd0,
        ERR_NO_LENGTH_TAG = 3'd1,
        ERR_LENGTH_OPEN   = 3'd2,
        ERR_NO_TRAILER    = 3'd3,
        ERR_LENGTH        = 3'd4,
        ERR_CHECKSUM      = 3'd5
    } err_t;

    typedef struct packed {
        logic             kind;
        logic [TAG_W-1:0] tag;
        logic [POS_W-1:0] offset;
        logic [POS_W-1:0] length;
        logic             ok;
        err_t             err;
        logic             last;
    } fmv_result_t;

    // Up to two results leave the parser per byte: field event, then verdict
    typedef struct packed {
        logic        first_valid;
        fmv_result_t first;
        logic        second_valid;
        fmv_result_t second;
    } fmv_push_t;

    // One decimal digit step: acc * 10 + digit, saturating at all ones
    function automatic logic [TAG_W-1:0] dec_step(input logic [TAG_W-1:0] acc,
                                                  input logic [3:0] digit);
        logic [TAG_W+3:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{TAG_W{1'b0}}, digit};
        if (sum[TAG_W+3:TAG_W] != 4'd0) begin
            return '1;
        end
        return sum[TAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fmv_parser.sv
// Byte parser: field splitting, tag and value decoding, length and checksum verdict.
`timescale 1ns / 1ps
`default_nettype none

module fmv_parser (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fmv_pkg::BYTE_W-1:0]    in_byte,
    input  wire logic                          in_last,
    input  wire logic                          space_ok,
    output fmv_pkg::fmv_push_t                 push
);
    import fmv_pkg::*;

    typedef enum logic [2:0] {
        PM_FRESH,
        PM_NINE,
        PM_ONE,
        PM_ONEZERO,
        PM_DEAD
    } prefix_t;

    // Input register
    logic              hold_valid_reg;
    logic [BYTE_W-1:0] hold_byte_reg;
    logic              hold_last_reg;
    logic              fire;

    // Message state
    prefix_t           prefix_reg, prefix_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  field_begin_reg, field_begin_next;
    logic              eq_seen_reg, eq_seen_next;
    logic [POS_W-1:0]  eq_pos_reg, eq_pos_next;
    logic [TAG_W-1:0]  tag_acc_reg, tag_acc_next;
    logic              tag_done_reg, tag_done_next;
    logic [TAG_W-1:0]  val_acc_reg, val_acc_next;
    logic              val_done_reg, val_done_next;
    logic [TAG_W-1:0]  claimed_len_reg, claimed_len_next;
    logic [TAG_W-1:0]  claimed_sum_reg, claimed_sum_next;
    logic              len_tag_seen_reg, len_tag_seen_next;
    logic              len_found_reg, len_found_next;
    logic              len_closed_reg, len_closed_next;
    logic [POS_W-1:0]  body_begin_reg, body_begin_next;
    logic              trailer_found_reg, trailer_found_next;
    logic [POS_W-1:0]  trailer_pos_reg, trailer_pos_next;
    logic [SUM_W-1:0]  run_sum_reg, run_sum_next;
    logic [SUM_W-1:0]  sum_fb_reg, sum_fb_next;
    logic [SUM_W-1:0]  sum_trl_reg, sum_trl_next;

    logic              is_soh;
    logic              is_digit;
    logic              is_equal;
    logic [TAG_W-1:0]  dec_out;
    logic              event_valid;
    logic [POS_W-1:0]  end_pos;
    logic [POS_W-1:0]  body_span;
    logic [SUM_W-1:0]  sum_with_byte;
    err_t              verdict_err;
    fmv_result_t       field_res;
    fmv_result_t       verdict_res;

    assign fire     = hold_valid_reg && space_ok;
    assign in_ready = !hold_valid_reg || fire;

    assign is_soh        = (hold_byte_reg == SOH_BYTE);
    assign is_equal      = (hold_byte_reg == CHAR_EQUAL);
    assign is_digit      = (hold_byte_reg >= CHAR_ZERO) && (hold_byte_reg <= CHAR_NINE);
    assign sum_with_byte = run_sum_reg + hold_byte_reg;

    // One shared decimal step: tag digits before '=', value digits after
    assign dec_out = dec_step(eq_seen_reg ? val_acc_reg : tag_acc_reg, hold_byte_reg[3:0]);

    // Advance the message state for the held byte
    always_comb begin
        prefix_next        = prefix_reg;
        pos_next           = pos_reg + POS_W'(1);
        field_begin_next   = field_begin_reg;
        eq_seen_next       = eq_seen_reg;
        eq_pos_next        = eq_pos_reg;
        tag_acc_next       = tag_acc_reg;
        tag_done_next      = tag_done_reg;
        val_acc_next       = val_acc_reg;
        val_done_next      = val_done_reg;
        claimed_len_next   = claimed_len_reg;
        claimed_sum_next   = claimed_sum_reg;
        len_tag_seen_next  = len_tag_seen_reg;
        len_found_next     = len_found_reg;
        len_closed_next    = len_closed_reg;
        body_begin_next    = body_begin_reg;
        trailer_found_next = trailer_found_reg;
        trailer_pos_next   = trailer_pos_reg;
        run_sum_next       = sum_with_byte;
        sum_fb_next        = sum_fb_reg;
        sum_trl_next       = sum_trl_reg;

        // Field content: prefix tracking and tag/value digits
        if (!is_soh) begin
            unique case (prefix_reg)
                PM_FRESH: begin
                    if (hold_byte_reg == CHAR_NINE) begin
                        prefix_next = PM_NINE;
                    end else if (hold_byte_reg == CHAR_ONE) begin
                        prefix_next = PM_ONE;
                    end else begin
                        prefix_next = PM_DEAD;
                    end
                end
                PM_NINE: begin
                    if (is_equal && !len_found_reg && !hold_last_reg) begin
                        len_found_next = 1'b1;
                    end
                    prefix_next = PM_DEAD;
                end
                PM_ONE: begin
                    prefix_next = (hold_byte_reg == CHAR_ZERO) ? PM_ONEZERO : PM_DEAD;
                end
                PM_ONEZERO: begin
                    if (is_equal && len_closed_reg && !trailer_found_reg && !hold_last_reg) begin
                        trailer_found_next = 1'b1;
                        trailer_pos_next   = field_begin_reg;
                        sum_trl_next       = sum_fb_reg;
                    end
                    prefix_next = PM_DEAD;
                end
                default: begin
                    prefix_next = PM_DEAD;
                end
            endcase

            if (!eq_seen_reg) begin
                if (is_equal) begin
                    eq_seen_next = 1'b1;
                    eq_pos_next  = pos_reg;
                end else if (!tag_done_reg) begin
                    if (is_digit) begin
                        tag_acc_next = dec_out;
                    end else begin
                        tag_done_next = 1'b1;
                    end
                end
            end else if (!val_done_reg) begin
                if (is_digit) begin
                    val_acc_next = dec_out;
                end else begin
                    val_done_next = 1'b1;
                end
            end
        end

        // Field close on SOH or on the final byte
        event_valid = (is_soh || hold_last_reg) && eq_seen_next;
        end_pos     = is_soh ? pos_reg : pos_reg + POS_W'(1);
        if (event_valid) begin
            if (tag_acc_next == TAG_MSG_LEN) begin
                len_tag_seen_next = 1'b1;
                claimed_len_next  = val_acc_next;
            end else if (tag_acc_next == TAG_CHECKSUM) begin
                claimed_sum_next = val_acc_next;
            end
        end

        field_res        = '0;
        field_res.kind   = KIND_FIELD;
        field_res.tag    = tag_acc_next;
        field_res.offset = eq_pos_next + POS_W'(1);
        field_res.length = end_pos - eq_pos_next - POS_W'(1);
        field_res.err    = ERR_NONE;

        // SOH: body starts after the first 9= field, then open a fresh field
        if (is_soh) begin
            if (len_found_reg && !len_closed_reg) begin
                len_closed_next = 1'b1;
                body_begin_next = pos_reg + POS_W'(1);
            end
            field_begin_next = pos_reg + POS_W'(1);
            sum_fb_next      = sum_with_byte;
            eq_seen_next     = 1'b0;
            eq_pos_next      = '0;
            tag_acc_next     = '0;
            tag_done_next    = 1'b0;
            val_acc_next     = '0;
            val_done_next    = 1'b0;
            prefix_next      = PM_FRESH;
        end

        // Verdict on the final byte, first failing check wins
        body_span = trailer_pos_next - body_begin_next;
        if (!len_tag_seen_next || !len_found_next) begin
            verdict_err = ERR_NO_LENGTH_TAG;
        end else if (!len_closed_next) begin
            verdict_err = ERR_LENGTH_OPEN;
        end else if (!trailer_found_next) begin
            verdict_err = ERR_NO_TRAILER;
        end else if ({{(TAG_W-POS_W){1'b0}}, body_span} != claimed_len_next) begin
            verdict_err = ERR_LENGTH;
        end else if ({{(TAG_W-SUM_W){1'b0}}, sum_trl_next} != claimed_sum_next) begin
            verdict_err = ERR_CHECKSUM;
        end else begin
            verdict_err = ERR_NONE;
        end

        verdict_res      = '0;
        verdict_res.kind = KIND_VERDICT;
        verdict_res.ok   = (verdict_err == ERR_NONE);
        verdict_res.err  = verdict_err;
        verdict_res.last = 1'b1;

        // Clear everything for the next message
        if (hold_last_reg) begin
            prefix_next        = PM_FRESH;
            pos_next           = '0;
            field_begin_next   = '0;
            eq_seen_next       = 1'b0;
            eq_pos_next        = '0;
            tag_acc_next       = '0;
            tag_done_next      = 1'b0;
            val_acc_next       = '0;
            val_done_next      = 1'b0;
            claimed_len_next   = '0;
            claimed_sum_next   = '0;
            len_tag_seen_next  = 1'b0;
            len_found_next     = 1'b0;
            len_closed_next    = 1'b0;
            body_begin_next    = '0;
            trailer_found_next = 1'b0;
            trailer_pos_next   = '0;
            run_sum_next       = '0;
            sum_fb_next        = '0;
            sum_trl_next       = '0;
        end

        // Results to the queue: field event first, verdict after it
        push.first_valid  = fire && (event_valid || hold_last_reg);
        push.first        = event_valid ? field_res : verdict_res;
        push.second_valid = fire && event_valid && hold_last_reg;
        push.second       = verdict_res;
    end

    // Hold the input transfer and commit state when the byte is processed
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            hold_byte_reg <= in_byte;
            hold_last_reg <= in_last;
        end
        if (!aresetn) begin
            hold_valid_reg    <= 1'b0;
            prefix_reg        <= PM_FRESH;
            pos_reg           <= '0;
            field_begin_reg   <= '0;
            eq_seen_reg       <= 1'b0;
            eq_pos_reg        <= '0;
            tag_acc_reg       <= '0;
            tag_done_reg      <= 1'b0;
            val_acc_reg       <= '0;
            val_done_reg      <= 1'b0;
            claimed_len_reg   <= '0;
            claimed_sum_reg   <= '0;
            len_tag_seen_reg  <= 1'b0;
            len_found_reg     <= 1'b0;
            len_closed_reg    <= 1'b0;
            body_begin_reg    <= '0;
            trailer_found_reg <= 1'b0;
            trailer_pos_reg   <= '0;
            run_sum_reg       <= '0;
            sum_fb_reg        <= '0;
            sum_trl_reg       <= '0;
        end else begin
            if (in_ready) begin
                hold_valid_reg <= in_valid;
            end
            if (fire) begin
                prefix_reg        <= prefix_next;
                pos_reg           <= pos_next;
                field_begin_reg   <= field_begin_next;
                eq_seen_reg       <= eq_seen_next;
                eq_pos_reg        <= eq_pos_next;
                tag_acc_reg       <= tag_acc_next;
                tag_done_reg      <= tag_done_next;
                val_acc_reg       <= val_acc_next;
                val_done_reg      <= val_done_next;
                claimed_len_reg   <= claimed_len_next;
                claimed_sum_reg   <= claimed_sum_next;
                len_tag_seen_reg  <= len_tag_seen_next;
                len_found_reg     <= len_found_next;
                len_closed_reg    <= len_closed_next;
                body_begin_reg    <= body_begin_next;
                trailer_found_reg <= trailer_found_next;
                trailer_pos_reg   <= trailer_pos_next;
                run_sum_reg       <= run_sum_next;
                sum_fb_reg        <= sum_fb_next;
                sum_trl_reg       <= sum_trl_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fmv_out_queue.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
`timescale 1ns / 1ps
`default_nettype none

module fmv_out_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire fmv_pkg::fmv_push_t   push,
    output logic                      space_ok,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output fmv_pkg::fmv_result_t      out_res
);
    import fmv_pkg::*;

    fmv_result_t          entry_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg, count_next;
    logic [OUT_PTR_W-1:0] wr_ptr_plus1;
    logic                 pop;
    logic [1:0]           push_cnt;

    assign out_valid    = (count_reg != '0);
    assign out_res      = entry_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign space_ok     = (count_reg <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + OUT_PTR_W'(1);
    assign push_cnt     = {1'b0, push.first_valid} + {1'b0, push.second_valid};

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + OUT_PTR_W'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + OUT_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OUT_CNT_W'(push_cnt) - OUT_CNT_W'(pop);
    end

    // Write entries in order
    always_ff @(posedge aclk) begin
        if (push.first_valid) begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid) begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fix_message_validator.sv
// Top level of the FIX message validator: byte stream in, field events and verdicts out.
//
// Usage: feed one message byte per transfer on the s_axis channel, with
// s_axis_tlast on the final byte of each message. Every SOH-terminated field
// that holds an '=' yields a field event on m_axis (tuser = 0) with its tag,
// value offset and value length. The final byte also yields a verdict
// (tuser = 1, tlast = 1) with message_ok and the error code; a field event
// closed by that byte comes first.
// Results: an accepted byte waits in the parser's input register, and its results
// are written to the queue once the queue has two free entries.
// Throughput: one byte per cycle; the parser takes a byte while the four-entry
// result queue has two free entries, so only a stalled receiver or a run of
// two-result bytes slows intake.
// Reset: synchronous, active low; clears the parser state and empties the
// queue. After each verdict the parser clears itself for the next message.
// A stalled receiver holds the head result steady; intake stops once the
// queue is nearly full.
`timescale 1ns / 1ps
`default_nettype none

module fix_message_validator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [fmv_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  wire logic                           s_axis_tlast,   // end_of_message
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [31:0] field_tag, [47:32] value_offset, [63:48] value_length,
    // [64] message_ok, [67:65] error_code, rest zero
    output logic [fmv_pkg::TDATA_W-1:0]         m_axis_tdata,
    output logic                                m_axis_tuser,   // result_kind
    output logic                                m_axis_tlast    // last_result
);
    import fmv_pkg::*;

    fmv_push_t   push;
    logic        space_ok;
    fmv_result_t head;

    fmv_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .space_ok (space_ok),
        .push     (push)
    );

    fmv_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (head)
    );

    // Pack the head result onto the output transfer
    assign m_axis_tdata = {{(TDATA_W - TDATA_RAW_W){1'b0}}, head.err, head.ok,
                           head.length, head.offset, head.tag};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire
